>>> sv/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
`default_nettype none
package qvr_pkg;
	localparam int QW = 16;
	localparam int VW = 32;
	localparam int MW = 34;
	localparam int NW = 33;
	localparam int PW = MW + VW;
	localparam int AW = PW + 2;
	localparam int GW = AW - 1;
	localparam int QB = 33;

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [MW-1:0] melem_t;
	typedef logic [NW-1:0] norm_t;
	typedef logic [GW-1:0] mag_t;

	typedef struct packed {
		logic vld;
		logic zero;
	} ctl_t;
endpackage
`default_nettype wire

>>> sv/qvr_matrix.sv
// Quaternion products, scaled rotation matrix and squared norm.
`default_nettype none
module qvr_matrix (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	input  wire qvr_pkg::quat_t  qa,
	input  wire qvr_pkg::quat_t  qb,
	input  wire qvr_pkg::quat_t  qc,
	input  wire qvr_pkg::quat_t  qd,
	input  wire qvr_pkg::vec_t   vin [3],
	output qvr_pkg::ctl_t        ctl,
	output qvr_pkg::melem_t      mat [9],
	output qvr_pkg::norm_t       norm,
	output qvr_pkg::vec_t        vout [3]
);
	import qvr_pkg::*;

	logic signed [31:0] aa_s1, bb_s1, cc_s1, dd_s1;
	logic signed [31:0] bc_s1, ad_s1, bd_s1, ac_s1, cd_s1, ab_s1;
	vec_t               v_s1 [3];
	logic               vld_s1, vld_s2;
	melem_t             m_s2 [9];
	norm_t              n_s2;
	logic               zero_s2;
	vec_t               v_s2 [3];
	norm_t              n_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		aa_s1 <= qa * qa;
		bb_s1 <= qb * qb;
		cc_s1 <= qc * qc;
		dd_s1 <= qd * qd;
		bc_s1 <= qb * qc;
		ad_s1 <= qa * qd;
		bd_s1 <= qb * qd;
		ac_s1 <= qa * qc;
		cd_s1 <= qc * qd;
		ab_s1 <= qa * qb;
		v_s1  <= vin;
	end

	assign n_c = NW'(aa_s1) + NW'(bb_s1) + NW'(cc_s1) + NW'(dd_s1);

	always_ff @(posedge clk) begin
		m_s2[0] <= MW'(aa_s1) + MW'(bb_s1) - MW'(cc_s1) - MW'(dd_s1);
		m_s2[1] <= (MW'(bc_s1) - MW'(ad_s1)) <<< 1;
		m_s2[2] <= (MW'(bd_s1) + MW'(ac_s1)) <<< 1;
		m_s2[3] <= (MW'(bc_s1) + MW'(ad_s1)) <<< 1;
		m_s2[4] <= MW'(aa_s1) - MW'(bb_s1) + MW'(cc_s1) - MW'(dd_s1);
		m_s2[5] <= (MW'(cd_s1) - MW'(ab_s1)) <<< 1;
		m_s2[6] <= (MW'(bd_s1) - MW'(ac_s1)) <<< 1;
		m_s2[7] <= (MW'(cd_s1) + MW'(ab_s1)) <<< 1;
		m_s2[8] <= MW'(aa_s1) - MW'(bb_s1) - MW'(cc_s1) + MW'(dd_s1);
		n_s2    <= n_c;
		zero_s2 <= (n_c == '0);
		v_s2    <= v_s1;
	end

	assign ctl  = '{vld: vld_s2, zero: zero_s2};
	assign mat  = m_s2;
	assign norm = n_s2;
	assign vout = v_s2;
endmodule
`default_nettype wire

>>> sv/qvr_mac.sv
// Matrix-vector products, row sums and sign-magnitude split.
`default_nettype none
module qvr_mac (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire qvr_pkg::ctl_t   in_ctl,
	input  wire qvr_pkg::melem_t mat [9],
	input  wire qvr_pkg::norm_t  in_norm,
	input  wire qvr_pkg::vec_t   vin [3],
	output qvr_pkg::ctl_t        ctl,
	output qvr_pkg::mag_t        mag [3],
	output logic                 neg [3],
	output qvr_pkg::norm_t       norm
);
	import qvr_pkg::*;

	logic signed [PW-1:0] p_s3 [9];
	logic signed [AW-1:0] acc_s4 [3];
	mag_t                 mag_s5 [3];
	logic                 neg_s5 [3];
	norm_t                n_s3, n_s4, n_s5;
	logic                 zero_s3, zero_s4, zero_s5;
	logic                 vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= in_ctl.vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			p_s3[i] <= mat[i] * vin[i % 3];
		end
		for (int r = 0; r < 3; r++) begin
			acc_s4[r] <= AW'(p_s3[3*r]) + AW'(p_s3[3*r+1]) + AW'(p_s3[3*r+2]);
			neg_s5[r] <= acc_s4[r][AW-1];
			mag_s5[r] <= acc_s4[r][AW-1] ? GW'(-acc_s4[r]) : GW'(acc_s4[r]);
		end
		n_s3    <= in_norm;
		n_s4    <= n_s3;
		n_s5    <= n_s4;
		zero_s3 <= in_ctl.zero;
		zero_s4 <= zero_s3;
		zero_s5 <= zero_s4;
	end

	assign ctl  = '{vld: vld_s5, zero: zero_s5};
	assign mag  = mag_s5;
	assign neg  = neg_s5;
	assign norm = n_s5;
endmodule
`default_nettype wire

>>> sv/qvr_div.sv
// Pipelined restoring divider with rounding and saturation, one bit per stage.
`default_nettype none
module qvr_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire qvr_pkg::ctl_t  in_ctl,
	input  wire qvr_pkg::mag_t  mag,
	input  wire logic           neg,
	input  wire qvr_pkg::norm_t norm,
	output qvr_pkg::ctl_t       ctl,
	output qvr_pkg::vec_t       res,
	output logic                ovf
);
	import qvr_pkg::*;

	logic [NW-1:0] rem_s [QB+1];
	logic [QB-1:0] lo_s  [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	norm_t         n_s   [QB+1];
	logic          big_s [QB+1];
	logic          neg_s [QB+1];
	logic          zero_s [QB+1];
	logic          vld_s [QB+1];
	vec_t          res_q;
	logic          ovf_q, vld_q, zero_q;
	logic [NW:0]   r0;
	logic [NW:0]   t   [QB+1];
	logic          ge  [QB+1];
	logic          rnd;
	logic [QB:0]   qr;
	logic          sat;

	assign r0 = (NW+1)'(mag[GW-1:QB]);

	always_comb begin
		t[0]  = '0;
		ge[0] = 1'b0;
		for (int k = 1; k <= QB; k++) begin
			t[k]  = {rem_s[k-1], lo_s[k-1][QB-1]};
			ge[k] = t[k] >= {1'b0, n_s[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) vld_s[k] <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			vld_s[0] <= in_ctl.vld;
			for (int k = 1; k <= QB; k++) vld_s[k] <= vld_s[k-1];
			vld_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= r0[NW-1:0];
		big_s[0]  <= r0 >= {1'b0, norm};
		lo_s[0]   <= mag[QB-1:0];
		quo_s[0]  <= '0;
		n_s[0]    <= norm;
		neg_s[0]  <= neg;
		zero_s[0] <= in_ctl.zero;
		for (int k = 1; k <= QB; k++) begin
			rem_s[k]  <= ge[k] ? NW'(t[k] - {1'b0, n_s[k-1]}) : t[k][NW-1:0];
			lo_s[k]   <= lo_s[k-1] << 1;
			quo_s[k]  <= {quo_s[k-1][QB-2:0], ge[k]};
			n_s[k]    <= n_s[k-1];
			big_s[k]  <= big_s[k-1];
			neg_s[k]  <= neg_s[k-1];
			zero_s[k] <= zero_s[k-1];
		end
	end

	assign rnd = {rem_s[QB], 1'b0} >= {1'b0, n_s[QB]};
	assign qr  = {1'b0, quo_s[QB]} + (QB+1)'(rnd);
	assign sat = big_s[QB] ||
		(neg_s[QB] ? (qr > (QB+1)'(34'h080000000)) : (qr > (QB+1)'(34'h07FFFFFFF)));

	always_ff @(posedge clk) begin
		zero_q <= zero_s[QB];
		ovf_q  <= sat;
		if (neg_s[QB]) begin
			res_q <= sat ? vec_t'(32'h80000000) : vec_t'(-qr[VW-1:0]);
		end else begin
			res_q <= sat ? vec_t'(32'h7FFFFFFF) : vec_t'(qr[VW-1:0]);
		end
	end

	assign ctl = '{vld: vld_q, zero: zero_q};
	assign res = res_q;
	assign ovf = ovf_q;
endmodule
`default_nettype wire

>>> sv/quaternion_vector_rotation.sv
// Top level: rotates a Q15.16 vector by a Q1.14 quaternion as q*(0,v)*q^-1.
// Throughput: one beat per cycle; busy stays low and the pipeline never stalls.
// The depth is set by the 33-stage bit-per-cycle divider by the squared norm.
// Reset clears only the valid bits; done stays low until a beat reaches the end.
`default_nettype none
module quaternion_vector_rotation (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire qvr_pkg::quat_t quat_w,
	input  wire qvr_pkg::quat_t quat_x,
	input  wire qvr_pkg::quat_t quat_y,
	input  wire qvr_pkg::quat_t quat_z,
	input  wire qvr_pkg::vec_t  vec_x,
	input  wire qvr_pkg::vec_t  vec_y,
	input  wire qvr_pkg::vec_t  vec_z,
	output logic                done,
	output qvr_pkg::vec_t       rot_x,
	output qvr_pkg::vec_t       rot_y,
	output qvr_pkg::vec_t       rot_z,
	output logic                norm_zero,
	output logic                overflow
);
	import qvr_pkg::*;

	vec_t   vin [3];
	ctl_t   m_ctl, a_ctl, d_ctl;
	melem_t mat [9];
	norm_t  m_norm, a_norm;
	vec_t   m_vec [3];
	mag_t   mag [3];
	logic   neg [3];
	vec_t   res [3];
	logic   ovf [3];

	assign busy   = 1'b0;
	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;

	qvr_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy),
		.qa(quat_w), .qb(quat_x), .qc(quat_y), .qd(quat_z), .vin(vin),
		.ctl(m_ctl), .mat(mat), .norm(m_norm), .vout(m_vec)
	);

	qvr_mac u_mac (
		.clk(clk), .arst_n(arst_n), .in_ctl(m_ctl), .mat(mat), .in_norm(m_norm),
		.vin(m_vec), .ctl(a_ctl), .mag(mag), .neg(neg), .norm(a_norm)
	);

	qvr_div u_div0 (
		.clk(clk), .arst_n(arst_n), .in_ctl(a_ctl), .mag(mag[0]), .neg(neg[0]),
		.norm(a_norm), .ctl(d_ctl), .res(res[0]), .ovf(ovf[0])
	);

	qvr_div u_div1 (
		.clk(clk), .arst_n(arst_n), .in_ctl(a_ctl), .mag(mag[1]), .neg(neg[1]),
		.norm(a_norm), .ctl(), .res(res[1]), .ovf(ovf[1])
	);

	qvr_div u_div2 (
		.clk(clk), .arst_n(arst_n), .in_ctl(a_ctl), .mag(mag[2]), .neg(neg[2]),
		.norm(a_norm), .ctl(), .res(res[2]), .ovf(ovf[2])
	);

	assign done      = d_ctl.vld;
	assign norm_zero = d_ctl.zero;
	assign rot_x     = d_ctl.zero ? '0 : res[0];
	assign rot_y     = d_ctl.zero ? '0 : res[1];
	assign rot_z     = d_ctl.zero ? '0 : res[2];
	assign overflow  = !d_ctl.zero && (ovf[0] || ovf[1] || ovf[2]);

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && norm_zero) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0 && !overflow))
		else $error("zero-norm beat carries nonzero result");

	a_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overflow) |-> (rot_x != 32'sh80000000 || ovf[0] == 1'b0))
		else $error("saturation flag lost on x lane");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(a_ctl.vld, QB + 2))
		else $error("result without a beat entering the divider");
endmodule
`default_nettype wire
